// ===== hw/rtl/bats_pkg.sv =====
// Shared types and constants for the blob autotile subtile selector.
// Used by the front, queue, back and top-level modules; depends on nothing.
package bats_pkg;

  localparam int MAX_MAP_WIDTH  = 256;
  localparam int MAX_MAP_HEIGHT = 256;
  localparam int TERRAIN_BITS   = 4;

  localparam int COORD_BITS = 8;
  localparam int SIZE_BITS  = 9;
  localparam int COUNT_BITS = 5;
  localparam int CODE_BITS  = 4;
  localparam int NOISE_BITS = 8;
  localparam int MAP_DEPTH  = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int ADDR_BITS  = $clog2(MAP_DEPTH);
  localparam int MAX_COUNT  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 9;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAP_WIDTH  = 3'd0,
    CFG_MAP_HEIGHT = 3'd1,
    CFG_VARIANTS0  = 3'd2,
    CFG_VARIANTS1  = 3'd3,
    CFG_VARIANTS2  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } back_state_t;

  localparam logic [CODE_BITS-1:0] SHP_TOP_LEFT     = 4'd0;
  localparam logic [CODE_BITS-1:0] SHP_TOP          = 4'd1;
  localparam logic [CODE_BITS-1:0] SHP_TOP_RIGHT    = 4'd2;
  localparam logic [CODE_BITS-1:0] SHP_LEFT         = 4'd3;
  localparam logic [CODE_BITS-1:0] SHP_CENTER       = 4'd4;
  localparam logic [CODE_BITS-1:0] SHP_RIGHT        = 4'd5;
  localparam logic [CODE_BITS-1:0] SHP_BOTTOM_LEFT  = 4'd6;
  localparam logic [CODE_BITS-1:0] SHP_BOTTOM       = 4'd7;
  localparam logic [CODE_BITS-1:0] SHP_BOTTOM_RIGHT = 4'd8;
  localparam logic [CODE_BITS-1:0] SHP_INV_TL       = 4'd9;
  localparam logic [CODE_BITS-1:0] SHP_INV_TR       = 4'd10;
  localparam logic [CODE_BITS-1:0] SHP_INV_BL       = 4'd11;
  localparam logic [CODE_BITS-1:0] SHP_INV_BR       = 4'd12;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  width;
    logic [SIZE_BITS-1:0]  height;
    logic [COUNT_BITS-1:0] count0;
    logic [COUNT_BITS-1:0] count1;
    logic [COUNT_BITS-1:0] count2;
  } cfg_t;

  typedef struct packed {
    op_t                             op;
    logic [COORD_BITS-1:0]           x;
    logic [COORD_BITS-1:0]           y;
    logic [TERRAIN_BITS-1:0]         terrain;
    logic                            fixed;
    logic [3:0][NOISE_BITS-1:0]      noise;
  } cmd_t;

  typedef struct packed {
    logic [3:0][CODE_BITS-1:0] subtile;
    logic [3:0][CODE_BITS-1:0] variant;
  } res_t;

endpackage

// ===== hw/rtl/bats_front.sv =====
// Front end: accepts input beats, drops those outside the map in use and
// packs the rest into queue commands. Depends on bats_pkg.
module bats_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [7:0]                      in_tile_x,
  input  logic [7:0]                      in_tile_y,
  input  logic [3:0]                      in_terrain_code,
  input  logic                            in_fixed_flag,
  input  logic [7:0]                      in_noise_q0,
  input  logic [7:0]                      in_noise_q1,
  input  logic [7:0]                      in_noise_q2,
  input  logic [7:0]                      in_noise_q3,
  input  bats_pkg::cfg_t                  cfg,
  input  logic                            q_full,
  output logic                            q_push,
  output bats_pkg::cmd_t                  q_cmd
);

  logic on_map;

  assign on_map = ({1'b0, in_tile_x} < cfg.width) && ({1'b0, in_tile_y} < cfg.height);
  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full && on_map;

  always_comb begin
    q_cmd.op       = bats_pkg::op_t'(in_opcode);
    q_cmd.x        = in_tile_x;
    q_cmd.y        = in_tile_y;
    q_cmd.terrain  = in_terrain_code[bats_pkg::TERRAIN_BITS-1:0];
    q_cmd.fixed    = in_fixed_flag;
    q_cmd.noise[0] = in_noise_q0;
    q_cmd.noise[1] = in_noise_q1;
    q_cmd.noise[2] = in_noise_q2;
    q_cmd.noise[3] = in_noise_q3;
  end

endmodule

// ===== hw/rtl/bats_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on bats_pkg for the command type and depth.
module bats_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bats_pkg::cmd_t push_cmd,
  input  logic           pop,
  output bats_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  bats_pkg::cmd_t                       entry_r [bats_pkg::QUEUE_DEPTH];
  logic [bats_pkg::QPTR_BITS-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [bats_pkg::QPTR_BITS-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [bats_pkg::QCNT_BITS-1:0]       count_r, count_nxt;
  logic                                 do_push, do_pop;

  assign full  = (count_r == bats_pkg::QCNT_BITS'(bats_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bats_pkg::QPTR_BITS'(bats_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bats_pkg::QPTR_BITS'(bats_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/bats_back.sv =====
// Back end: owns the tile map memory, performs writes and runs the nine-read
// neighbor sequence of a classify, then loads the result register. Depends on bats_pkg.
module bats_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bats_pkg::cfg_t cfg,
  input  bats_pkg::cmd_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output bats_pkg::res_t res
);

  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] LAST_STEP = 4'd9;

  typedef struct packed {
    logic xm;
    logic xp;
    logic ym;
    logic yp;
  } nb_off_t;

  function automatic nb_off_t nb_offset(input logic [STEP_BITS-1:0] step);
    nb_off_t o;
    o = '0;
    case (step)
      4'd1: o.ym = 1'b1;
      4'd2: o.xm = 1'b1;
      4'd3: o.xp = 1'b1;
      4'd4: o.yp = 1'b1;
      4'd5: begin o.xm = 1'b1; o.ym = 1'b1; end
      4'd6: begin o.xp = 1'b1; o.ym = 1'b1; end
      4'd7: begin o.xm = 1'b1; o.yp = 1'b1; end
      4'd8: begin o.xp = 1'b1; o.yp = 1'b1; end
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic logic [bats_pkg::CODE_BITS-1:0] quarter(
    input logic a, input logic k, input logic c,
    input logic [bats_pkg::CODE_BITS-1:0] corner,
    input logic [bats_pkg::CODE_BITS-1:0] a_only,
    input logic [bats_pkg::CODE_BITS-1:0] c_only,
    input logic [bats_pkg::CODE_BITS-1:0] inv);
    logic [bats_pkg::CODE_BITS-1:0] code;
    case ({c, a})
      2'b00:   code = corner;
      2'b01:   code = a_only;
      2'b10:   code = c_only;
      default: code = k ? bats_pkg::SHP_CENTER : inv;
    endcase
    return code;
  endfunction

  function automatic logic [bats_pkg::CODE_BITS-1:0] variant_of(
    input logic [bats_pkg::NOISE_BITS-1:0] noise,
    input logic [bats_pkg::COUNT_BITS-1:0] count);
    logic [12:0] prod;
    prod = 13'(noise) * 13'(count) - 13'd1;
    return (noise == '0) ? '0 : prod[11:8];
  endfunction

  logic [bats_pkg::TERRAIN_BITS:0]        map_mem [bats_pkg::MAP_DEPTH];
  logic [bats_pkg::TERRAIN_BITS:0]        rd_data_r;
  logic [bats_pkg::ADDR_BITS-1:0]         rd_addr, wr_addr;
  logic                                   mem_we;

  bats_pkg::back_state_t                  state_r, state_nxt;
  logic [STEP_BITS-1:0]                   step_r, step_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  logic                                   load_cur, load_res;

  bats_pkg::cmd_t                         cur_r;
  logic                                   inb_d_r;
  logic [bats_pkg::TERRAIN_BITS-1:0]      own_r;
  logic                                   fixed_r;
  logic [7:0]                             match_r;
  bats_pkg::res_t                         res_r;

  nb_off_t                                off;
  logic [bats_pkg::SIZE_BITS-1:0]         x_ext, y_ext, nx, ny;
  logic                                   inb;
  logic [bats_pkg::COUNT_BITS-1:0]        count;
  logic [3:0][bats_pkg::CODE_BITS-1:0]    var_raw;
  bats_pkg::res_t                         res_nxt;
  logic [2:0]                             match_idx;

  // Neighbor address for the read issued in this cycle.
  always_comb begin
    off   = nb_offset(step_r);
    x_ext = {1'b0, cur_r.x};
    y_ext = {1'b0, cur_r.y};
    nx    = off.xm ? x_ext - 1'b1 : (off.xp ? x_ext + 1'b1 : x_ext);
    ny    = off.ym ? y_ext - 1'b1 : (off.yp ? y_ext + 1'b1 : y_ext);
    inb   = !(off.xm && cur_r.x == '0) && !(off.xp && nx >= cfg.width) &&
            !(off.ym && cur_r.y == '0) && !(off.yp && ny >= cfg.height);
    rd_addr = bats_pkg::ADDR_BITS'(ny[bats_pkg::COORD_BITS-1:0]) *
              bats_pkg::ADDR_BITS'(bats_pkg::MAX_MAP_WIDTH) +
              bats_pkg::ADDR_BITS'(nx[bats_pkg::COORD_BITS-1:0]);
    wr_addr = bats_pkg::ADDR_BITS'(q_head.y) *
              bats_pkg::ADDR_BITS'(bats_pkg::MAX_MAP_WIDTH) +
              bats_pkg::ADDR_BITS'(q_head.x);
  end

  // Result assembly from the collected matches. Bit order of match_r:
  // top, left, right, bottom, top-left, top-right, bottom-left, bottom-right.
  always_comb begin
    case (own_r)
      bats_pkg::TERRAIN_BITS'(0): count = cfg.count0;
      bats_pkg::TERRAIN_BITS'(1): count = cfg.count1;
      bats_pkg::TERRAIN_BITS'(2): count = cfg.count2;
      default:                    count = bats_pkg::COUNT_BITS'(1);
    endcase
    for (int j = 0; j < 4; j++) begin
      var_raw[j] = variant_of(cur_r.noise[j], count);
    end
    res_nxt.subtile[0] = quarter(match_r[0], match_r[4], match_r[1], bats_pkg::SHP_TOP_LEFT,
                                 bats_pkg::SHP_LEFT, bats_pkg::SHP_TOP, bats_pkg::SHP_INV_TL);
    res_nxt.subtile[1] = quarter(match_r[2], match_r[5], match_r[0], bats_pkg::SHP_TOP_RIGHT,
                                 bats_pkg::SHP_TOP, bats_pkg::SHP_RIGHT, bats_pkg::SHP_INV_TR);
    res_nxt.subtile[2] = quarter(match_r[3], match_r[6], match_r[1],
                                 bats_pkg::SHP_BOTTOM_LEFT, bats_pkg::SHP_LEFT,
                                 bats_pkg::SHP_BOTTOM, bats_pkg::SHP_INV_BL);
    res_nxt.subtile[3] = quarter(match_r[2], match_r[7], match_r[3],
                                 bats_pkg::SHP_BOTTOM_RIGHT, bats_pkg::SHP_BOTTOM,
                                 bats_pkg::SHP_RIGHT, bats_pkg::SHP_INV_BR);
    res_nxt.variant[0] = var_raw[0];
    for (int j = 1; j < 4; j++) begin
      res_nxt.variant[j] = fixed_r ? var_raw[0] : var_raw[j];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    load_cur      = 1'b0;
    load_res      = 1'b0;
    unique case (state_r)
      bats_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.op == bats_pkg::OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            load_cur  = 1'b1;
            step_nxt  = '0;
            state_nxt = bats_pkg::ST_READ;
          end
        end
      end
      bats_pkg::ST_READ: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = bats_pkg::ST_DONE;
        end
      end
      bats_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_res      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bats_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bats_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bats_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wr_addr] <= {q_head.fixed, q_head.terrain};
    end
    rd_data_r <= map_mem[rd_addr];
  end

  assign match_idx = 3'(step_r - 4'd2);

  always_ff @(posedge clk) begin
    inb_d_r <= inb;
    if (load_cur) begin
      cur_r <= q_head;
    end
    if (state_r == bats_pkg::ST_READ) begin
      if (step_r == 4'd1) begin
        own_r   <= rd_data_r[bats_pkg::TERRAIN_BITS-1:0];
        fixed_r <= rd_data_r[bats_pkg::TERRAIN_BITS];
      end else if (step_r >= 4'd2) begin
        match_r[match_idx] <= !inb_d_r ||
                              (rd_data_r[bats_pkg::TERRAIN_BITS-1:0] == own_r);
      end
    end
    if (load_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ===== hw/rtl/blob_autotile_subtile_select.sv =====
// Top level of the blob autotile subtile selector: configuration registers,
// front end, command queue and back end. Depends on bats_pkg, bats_front,
// bats_queue and bats_back.
//
//   Input channel (in_valid/in_ready): one beat is a write (opcode 0) that
//   stores a terrain code and fixed flag at tile_x, tile_y, or a classify
//   (opcode 1) that returns one result beat with four quarter shape codes and
//   four graphic variants. Beats outside the map in use are taken and dropped.
//   Result channel (out_valid/out_ready): one registered beat per classify.
//   Configuration channel (cfg_valid/cfg_ready): always ready; write only
//   while no classify is in flight.
//   A write is performed by the back end when it is popped from the queue; a
//   classify runs nine sequential reads through the single read port of the
//   tile map, then a done state loads the result register. The back end takes
//   no new command until that classify is done; one write per cycle while idle.
//   A two-entry command queue takes new beats while the back end works; when
//   the receiver stalls, the back end holds its finished result, the queue
//   fills and in_ready drops. Reset clears all control state and sets width
//   and height to 256 and all variant counts to 1; the tile map is not cleared.
module blob_autotile_subtile_select (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [7:0] in_tile_x,
  input  logic [7:0] in_tile_y,
  input  logic [3:0] in_terrain_code,
  input  logic       in_fixed_flag,
  input  logic [7:0] in_noise_q0,
  input  logic [7:0] in_noise_q1,
  input  logic [7:0] in_noise_q2,
  input  logic [7:0] in_noise_q3,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_subtile_q0,
  output logic [3:0] out_subtile_q1,
  output logic [3:0] out_subtile_q2,
  output logic [3:0] out_subtile_q3,
  output logic [3:0] out_variant_q0,
  output logic [3:0] out_variant_q1,
  output logic [3:0] out_variant_q2,
  output logic [3:0] out_variant_q3,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [bats_pkg::SIZE_BITS-1:0]  map_width_r, map_height_r;
  logic [bats_pkg::COUNT_BITS-1:0] variants0_r, variants1_r, variants2_r;
  bats_pkg::cfg_t                  cfg;
  bats_pkg::cmd_t                  push_cmd, head;
  bats_pkg::res_t                  res;
  logic                            q_push, q_pop, q_full, q_empty;

  function automatic logic [bats_pkg::SIZE_BITS-1:0] clamp_size(
    input logic [bats_pkg::SIZE_BITS-1:0] v, input logic [bats_pkg::SIZE_BITS-1:0] max);
    return (v == '0) ? bats_pkg::SIZE_BITS'(1) : ((v > max) ? max : v);
  endfunction

  function automatic logic [bats_pkg::COUNT_BITS-1:0] clamp_count(
    input logic [bats_pkg::COUNT_BITS-1:0] c);
    return (c == '0) ? bats_pkg::COUNT_BITS'(1) :
           ((c > bats_pkg::COUNT_BITS'(bats_pkg::MAX_COUNT)) ?
            bats_pkg::COUNT_BITS'(bats_pkg::MAX_COUNT) : c);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= bats_pkg::SIZE_BITS'(256);
      map_height_r <= bats_pkg::SIZE_BITS'(256);
      variants0_r  <= bats_pkg::COUNT_BITS'(1);
      variants1_r  <= bats_pkg::COUNT_BITS'(1);
      variants2_r  <= bats_pkg::COUNT_BITS'(1);
    end else if (cfg_valid) begin
      unique case (bats_pkg::cfg_idx_t'(cfg_index))
        bats_pkg::CFG_MAP_WIDTH:  map_width_r  <= cfg_data;
        bats_pkg::CFG_MAP_HEIGHT: map_height_r <= cfg_data;
        bats_pkg::CFG_VARIANTS0:  variants0_r  <= cfg_data[bats_pkg::COUNT_BITS-1:0];
        bats_pkg::CFG_VARIANTS1:  variants1_r  <= cfg_data[bats_pkg::COUNT_BITS-1:0];
        bats_pkg::CFG_VARIANTS2:  variants2_r  <= cfg_data[bats_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width  = clamp_size(map_width_r, bats_pkg::SIZE_BITS'(bats_pkg::MAX_MAP_WIDTH));
    cfg.height = clamp_size(map_height_r, bats_pkg::SIZE_BITS'(bats_pkg::MAX_MAP_HEIGHT));
    cfg.count0 = clamp_count(variants0_r);
    cfg.count1 = clamp_count(variants1_r);
    cfg.count2 = clamp_count(variants2_r);
  end

  bats_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_tile_x       (in_tile_x),
    .in_tile_y       (in_tile_y),
    .in_terrain_code (in_terrain_code),
    .in_fixed_flag   (in_fixed_flag),
    .in_noise_q0     (in_noise_q0),
    .in_noise_q1     (in_noise_q1),
    .in_noise_q2     (in_noise_q2),
    .in_noise_q3     (in_noise_q3),
    .cfg             (cfg),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  bats_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  bats_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_head    (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_subtile_q0 = res.subtile[0];
  assign out_subtile_q1 = res.subtile[1];
  assign out_subtile_q2 = res.subtile[2];
  assign out_subtile_q3 = res.subtile[3];
  assign out_variant_q0 = res.variant[0];
  assign out_variant_q1 = res.variant[1];
  assign out_variant_q2 = res.variant[2];
  assign out_variant_q3 = res.variant[3];

endmodule

// ===== hw/rtl/bats_checker.sv =====
// Port-level checks for blob_autotile_subtile_select, attached by bind.
// Depends only on the top level's port list.
module bats_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_subtile_q0,
  input logic [3:0] out_subtile_q1,
  input logic [3:0] out_subtile_q2,
  input logic [3:0] out_subtile_q3,
  input logic [3:0] out_variant_q0
);

  // A stalled result beat stays valid and keeps its quarter-0 shape code and variant.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_subtile_q0) &&
    $stable(out_variant_q0))
    else $error("result beat changed while stalled");

  // Reset removes any pending result.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Shape codes stay within the thirteen defined shapes.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_subtile_q0 <= 4'd12 && out_subtile_q1 <= 4'd12 &&
    out_subtile_q2 <= 4'd12 && out_subtile_q3 <= 4'd12)
    else $error("shape code out of range");

  // Both top quarters see the same top neighbor: an open top on the left
  // quarter means an open top on the right quarter.
  a_top_shared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_subtile_q0 == 4'd0 || out_subtile_q0 == 4'd1) |->
    (out_subtile_q1 == 4'd2 || out_subtile_q1 == 4'd1))
    else $error("top quarters disagree on the top neighbor");

endmodule

bind blob_autotile_subtile_select bats_checker u_bats_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_subtile_q0 (out_subtile_q0),
  .out_subtile_q1 (out_subtile_q1),
  .out_subtile_q2 (out_subtile_q2),
  .out_subtile_q3 (out_subtile_q3),
  .out_variant_q0 (out_variant_q0)
);
